@@ src/rob_pkg.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer package
// Shared types, operation and status codes, and stream field layout for the
// reorder buffer core and its submodules.
// ----------------------------------------------------------------------------
package rob_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned OP_W     = 3;
    localparam int unsigned KIND_W   = 8;
    localparam int unsigned DATA_W   = 16;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FILL_W   = 4;

    // Kind code that marks a store; stores never forward on lookup.
    localparam logic [KIND_W-1:0] STORE_KIND = 8'd115;

    // Stream widths: input word carries everything but the operation code,
    // output word carries everything but the status code.
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 72;

    // Operation codes carried in s_tuser.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 3'd0,
        OP_READY  = 3'd1,
        OP_SETDST = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_COMMIT = 3'd4,
        OP_FLUSH  = 3'd5,
        OP_READ   = 3'd6
    } rob_op_t;

    // Status codes carried in m_tuser.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOK,
        ST_FETCH,
        ST_POST
    } rob_state_t;

    // One input word, unpacked.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [KIND_W-1:0]        kind_in;
        logic [DATA_W-1:0]        dest_in;
        logic [DATA_W-1:0]        pc_in;
        logic [SLOT_W-1:0]        slot_in;
        logic signed [DATA_W-1:0] value_in;
    } rob_item_t;

    // One result word, unpacked.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SLOT_W-1:0]        slot;
        logic                     hit;
        logic signed [DATA_W-1:0] data_value;
        logic [KIND_W-1:0]        kind_out;
        logic [DATA_W-1:0]        dest_out;
        logic [DATA_W-1:0]        pc_out;
        logic                     ready_out;
        logic [SLOT_W-1:0]        head_slot;
        logic                     head_ready;
        logic [FILL_W-1:0]        fill_level;
    } rob_result_t;

endpackage

@@ src/reorder_buffer_core.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer core
// Circular reorder buffer with allocate, mark-ready, set-destination, lookup,
// commit, flush and read operations on a stream interface.
// Each accepted word runs through the execute and post states, and its result
// is then registered at the output; commit and read entry add a fetch state,
// and lookup adds a walk state. A word is taken only in the idle state, so the
// next word waits until the last result has gone to the output register. Lookup
// walks occupied entries through one compare unit, one entry per cycle, and a
// hit ends the walk. The output register lets a result wait while the next word
// is accepted. Reset (aresetn low, synchronous) empties the buffer.
// ----------------------------------------------------------------------------
module reorder_buffer_core #(
    parameter int unsigned ROB_DEPTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // kind_in[7:0], dest_in[23:8], pc_in[39:24], slot_in[42:40],
    // value_in[58:43], zero fill above
    input  logic [rob_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[2:0]
    input  logic [rob_pkg::OP_W-1:0]        s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot[2:0], hit[3], data_value[19:4], kind_out[27:20], dest_out[43:28],
    // pc_out[59:44], ready_out[60], head_slot[63:61], head_ready[64],
    // fill_level[68:65], zero fill above
    output logic [rob_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [rob_pkg::STATUS_W-1:0]    m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    rob_pkg::rob_item_t   item;
    rob_pkg::rob_result_t res;
    logic                 res_valid, res_ready;

    logic                                 m_tvalid_reg;
    logic [rob_pkg::M_TDATA_W-1:0]        m_tdata_reg;
    logic [rob_pkg::STATUS_W-1:0]         m_tuser_reg;

    // Input word unpacking.
    assign item.op       = s_tuser;
    assign item.kind_in  = s_tdata[7:0];
    assign item.dest_in  = s_tdata[23:8];
    assign item.pc_in    = s_tdata[39:24];
    assign item.slot_in  = s_tdata[42:40];
    assign item.value_in = s_tdata[58:43];

    rob_ctrl #(.ROB_DEPTH(ROB_DEPTH)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(s_tvalid),
        .item_ready(s_tready),
        .item      (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads when empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tuser_reg <= res.status;
            m_tdata_reg <= {3'b000, res.fill_level, res.head_ready, res.head_slot,
                            res.ready_out, res.pc_out, res.dest_out, res.kind_out,
                            res.data_value, res.hit, res.slot};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ src/rob_ram.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer RAM
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module rob_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/rob_ctrl.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer sequencer
// Holds the entry storage and pointers and runs one operation at a time.
// Lookup walks the occupied entries youngest first through a single compare
// unit, one entry per cycle.
// ----------------------------------------------------------------------------
module rob_ctrl #(
    parameter int unsigned ROB_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  rob_pkg::rob_item_t   item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output rob_pkg::rob_result_t res
);

    localparam int unsigned IDX_W = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(ROB_DEPTH + 1);
    localparam int unsigned SX_W  = IDX_W + 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROB_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ROB_DEPTH);

    rob_pkg::rob_state_t  state_reg, state_next;
    rob_pkg::rob_item_t   item_reg, item_next;
    rob_pkg::rob_result_t res_reg, res_next;

    logic [ROB_DEPTH-1:0] valid_reg, valid_next;
    logic [ROB_DEPTH-1:0] ready_reg, ready_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [IDX_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     iss_cnt_reg, iss_cnt_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;

    // Memory port signals.
    logic                      kind_we, dest_we, value_we, pc_we;
    logic [IDX_W-1:0]          wr_addr, rd_addr;
    logic [rob_pkg::DATA_W-1:0] value_wdata;
    logic [rob_pkg::KIND_W-1:0] kind_rd;
    logic [rob_pkg::DATA_W-1:0] dest_rd, value_rd, pc_rd;

    // Slot index from the item, with its range check.
    logic [SX_W-1:0]  slot_ext;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_ok;
    logic             match;
    logic [IDX_W-1:0] prev_ptr;

    assign slot_ext = SX_W'(item_reg.slot_in);
    assign slot_idx = slot_ext[IDX_W-1:0];
    assign slot_ok  = slot_ext < SX_W'(ROB_DEPTH);

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    // Entry field memories.
    rob_ram #(.WIDTH(rob_pkg::KIND_W), .DEPTH(ROB_DEPTH)) u_kind_ram (
        .aclk(aclk), .wr_en(kind_we), .wr_addr(wr_addr), .wr_data(item_reg.kind_in),
        .rd_addr(rd_addr), .rd_data(kind_rd)
    );
    rob_ram #(.WIDTH(rob_pkg::DATA_W), .DEPTH(ROB_DEPTH)) u_dest_ram (
        .aclk(aclk), .wr_en(dest_we), .wr_addr(wr_addr), .wr_data(item_reg.dest_in),
        .rd_addr(rd_addr), .rd_data(dest_rd)
    );
    rob_ram #(.WIDTH(rob_pkg::DATA_W), .DEPTH(ROB_DEPTH)) u_value_ram (
        .aclk(aclk), .wr_en(value_we), .wr_addr(wr_addr), .wr_data(value_wdata),
        .rd_addr(rd_addr), .rd_data(value_rd)
    );
    rob_ram #(.WIDTH(rob_pkg::DATA_W), .DEPTH(ROB_DEPTH)) u_pc_ram (
        .aclk(aclk), .wr_en(pc_we), .wr_addr(wr_addr), .wr_data(item_reg.pc_in),
        .rd_addr(rd_addr), .rd_data(pc_rd)
    );

    // Shared compare unit: the entry read last cycle against the lookup key.
    assign match = pend_reg && valid_reg[cmp_idx_reg] && ready_reg[cmp_idx_reg] &&
                   (kind_rd != rob_pkg::STORE_KIND) && (dest_rd == item_reg.dest_in);
    assign prev_ptr = wrap_dec(rd_ptr_reg);

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rob_pkg::ST_IDLE;
            valid_reg <= '0;
            ready_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            ready_reg <= ready_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        rd_ptr_reg  <= rd_ptr_next;
        iss_cnt_reg <= iss_cnt_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    // Sequencer: next state, memory ports and result fields.
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        valid_next   = valid_reg;
        ready_next   = ready_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        rd_ptr_next  = rd_ptr_reg;
        iss_cnt_next = iss_cnt_reg;
        pend_next    = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        kind_we      = 1'b0;
        dest_we      = 1'b0;
        value_we     = 1'b0;
        pc_we        = 1'b0;
        wr_addr      = tail_reg;
        value_wdata  = item_reg.value_in;
        rd_addr      = head_reg;
        item_ready   = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            rob_pkg::ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    item_next  = item;
                    res_next   = '0;
                    state_next = rob_pkg::ST_EXEC;
                end
            end

            rob_pkg::ST_EXEC: begin
                state_next = rob_pkg::ST_POST;
                unique case (rob_pkg::rob_op_t'(item_reg.op))
                    rob_pkg::OP_ALLOC: begin
                        if (fill_reg == FULL_CNT) begin
                            res_next.status = rob_pkg::STATUS_FULL;
                        end else begin
                            kind_we              = 1'b1;
                            dest_we              = 1'b1;
                            value_we             = 1'b1;
                            pc_we                = 1'b1;
                            value_wdata          = '0;
                            valid_next[tail_reg] = 1'b1;
                            ready_next[tail_reg] = 1'b0;
                            res_next.slot        = rob_pkg::SLOT_W'(tail_reg);
                            tail_next            = wrap_inc(tail_reg);
                            fill_next            = fill_reg + 1'b1;
                        end
                    end
                    rob_pkg::OP_READY: begin
                        wr_addr = slot_idx;
                        if (slot_ok) begin
                            value_we             = 1'b1;
                            ready_next[slot_idx] = 1'b1;
                        end
                    end
                    rob_pkg::OP_SETDST: begin
                        wr_addr = slot_idx;
                        dest_we = slot_ok;
                    end
                    rob_pkg::OP_LOOKUP: begin
                        rd_ptr_next  = tail_reg;
                        iss_cnt_next = '0;
                        state_next   = rob_pkg::ST_LOOK;
                    end
                    rob_pkg::OP_COMMIT: begin
                        if (fill_reg == '0) begin
                            res_next.status = rob_pkg::STATUS_EMPTY;
                        end else begin
                            rd_addr    = head_reg;
                            state_next = rob_pkg::ST_FETCH;
                        end
                    end
                    rob_pkg::OP_FLUSH: begin
                        valid_next = '0;
                        tail_next  = head_reg;
                        fill_next  = '0;
                    end
                    rob_pkg::OP_READ: begin
                        rd_addr = slot_idx;
                        if (slot_ok) begin
                            state_next = rob_pkg::ST_FETCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            rob_pkg::ST_LOOK: begin
                // Compare the pending entry, then issue the next older one.
                rd_addr = prev_ptr;
                if (match) begin
                    res_next.hit        = 1'b1;
                    res_next.data_value = value_rd;
                    state_next          = rob_pkg::ST_POST;
                end else if (iss_cnt_reg != fill_reg) begin
                    rd_ptr_next  = prev_ptr;
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                    pend_next    = 1'b1;
                    cmp_idx_next = prev_ptr;
                end else begin
                    state_next = rob_pkg::ST_POST;
                end
            end

            rob_pkg::ST_FETCH: begin
                res_next.data_value = value_rd;
                res_next.kind_out   = kind_rd;
                res_next.dest_out   = dest_rd;
                res_next.pc_out     = pc_rd;
                state_next          = rob_pkg::ST_POST;
                if (rob_pkg::rob_op_t'(item_reg.op) == rob_pkg::OP_COMMIT) begin
                    res_next.slot        = rob_pkg::SLOT_W'(head_reg);
                    valid_next[head_reg] = 1'b0;
                    fill_next            = fill_reg - 1'b1;
                    if (fill_reg == CNT_W'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                    end else begin
                        head_next = wrap_inc(head_reg);
                    end
                end else begin
                    res_next.ready_out = ready_reg[slot_idx];
                end
            end

            rob_pkg::ST_POST: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = rob_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rob_pkg::ST_IDLE;
            end
        endcase
    end

    // Result word with the head and fill snapshot after the operation.
    always_comb begin
        res            = res_reg;
        res.head_slot  = rob_pkg::SLOT_W'(head_reg);
        res.head_ready = valid_reg[head_reg] && ready_reg[head_reg];
        res.fill_level = rob_pkg::FILL_W'(fill_reg);
    end

endmodule

@@ src/rob_checker.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rob_checker #(
    parameter int unsigned ROB_DEPTH = 8
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [rob_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rob_pkg::STATUS_W-1:0]  m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A refused allocate is reported only with a full buffer.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rob_pkg::STATUS_FULL) |->
        (m_tdata[68:65] == rob_pkg::FILL_W'(ROB_DEPTH)))
        else $error("full status with buffer not full");

    // An ignored commit leaves an empty buffer with nothing reported.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == rob_pkg::STATUS_EMPTY) |->
        (m_tdata[68:65] == '0) && (m_tdata[59:0] == '0) && !m_tdata[64])
        else $error("empty status with entries or data reported");

    // A lookup hit is always a completed operation, never a full or empty report.
    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> (m_tuser == rob_pkg::STATUS_DONE) && (m_tdata[68:65] != '0))
        else $error("lookup hit with bad status or empty buffer");

endmodule

bind reorder_buffer_core rob_checker #(.ROB_DEPTH(ROB_DEPTH)) u_rob_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);

@@ tb/tb_reorder_buffer_core.sv @@
// ----------------------------------------------------------------------------
// Reorder buffer core testbench
// Drives operation words into the core and tracks a shadow copy of the buffer
// to predict every result word. Results are checked field by field in order.
// A short directed sequence covers the empty and full corners, store entries
// and commit of the last entry. A long random run follows with idle cycles
// on both streams, a drain pause and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_reorder_buffer_core;

    localparam int unsigned ROB_DEPTH    = 8;
    localparam int unsigned RANDOM_WORDS = 1050;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned HOLD_AT      = 700;
    localparam int unsigned DRAIN_AT     = 400;

    logic                            aclk;
    logic                            aresetn;
    logic [rob_pkg::S_TDATA_W-1:0]   s_tdata;
    logic [rob_pkg::OP_W-1:0]        s_tuser;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [rob_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [rob_pkg::STATUS_W-1:0]    m_tuser;
    logic                            m_tvalid;
    logic                            m_tready;

    int unsigned cycle_count    = 0;
    int unsigned words_accepted = 0;
    bit          hold_done      = 1'b0;

    // Destinations reused often so that lookups find matches.
    logic [rob_pkg::DATA_W-1:0] dest_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h00A5};

    // Shadow copy of the buffer and the queue of results still to arrive.
    class rob_shadow;
        bit                         occupied [ROB_DEPTH];
        bit                         ready_mark [ROB_DEPTH];
        bit                         ever_allocated [ROB_DEPTH];
        logic [rob_pkg::KIND_W-1:0] kind_mem [ROB_DEPTH];
        logic [rob_pkg::DATA_W-1:0] dest_mem [ROB_DEPTH];
        logic [rob_pkg::DATA_W-1:0] value_mem [ROB_DEPTH];
        logic [rob_pkg::DATA_W-1:0] pc_mem [ROB_DEPTH];
        int unsigned                head;
        int unsigned                tail;
        int unsigned                fill;
        rob_pkg::rob_result_t       pending_results [$];
        int unsigned                mismatches;

        // Apply one accepted word to the shadow state and queue its result.
        function void note_word(rob_pkg::rob_item_t w);
            rob_pkg::rob_result_t r;
            int unsigned i;
            int unsigned s;
            bit          found;
            r = '0;
            s = w.slot_in;
            case (rob_pkg::rob_op_t'(w.op))
                rob_pkg::OP_ALLOC: begin
                    if (fill >= ROB_DEPTH) begin
                        r.status = rob_pkg::STATUS_FULL;
                    end else begin
                        i = tail;
                        occupied[i]       = 1'b1;
                        ready_mark[i]     = 1'b0;
                        ever_allocated[i] = 1'b1;
                        kind_mem[i]       = w.kind_in;
                        dest_mem[i]       = w.dest_in;
                        value_mem[i]      = '0;
                        pc_mem[i]         = w.pc_in;
                        r.slot            = rob_pkg::SLOT_W'(i);
                        tail              = (tail + 1) % ROB_DEPTH;
                        fill++;
                    end
                end
                rob_pkg::OP_READY: begin
                    ready_mark[s] = 1'b1;
                    value_mem[s]  = w.value_in;
                end
                rob_pkg::OP_SETDST: begin
                    dest_mem[s] = w.dest_in;
                end
                rob_pkg::OP_LOOKUP: begin
                    // Walk from the youngest entry toward the head.
                    i = tail;
                    found = 1'b0;
                    for (int k = 0; k < fill && !found; k++) begin
                        i = (i + ROB_DEPTH - 1) % ROB_DEPTH;
                        if (occupied[i] && ready_mark[i] &&
                            kind_mem[i] != rob_pkg::STORE_KIND &&
                            dest_mem[i] == w.dest_in) begin
                            found        = 1'b1;
                            r.hit        = 1'b1;
                            r.data_value = value_mem[i];
                        end
                    end
                end
                rob_pkg::OP_COMMIT: begin
                    if (fill == 0) begin
                        r.status = rob_pkg::STATUS_EMPTY;
                    end else begin
                        i = head;
                        r.slot       = rob_pkg::SLOT_W'(i);
                        r.data_value = value_mem[i];
                        r.kind_out   = kind_mem[i];
                        r.dest_out   = dest_mem[i];
                        r.pc_out     = pc_mem[i];
                        occupied[i]  = 1'b0;
                        if (fill == 1) begin
                            head = 0;
                            tail = 0;
                        end else begin
                            head = (head + 1) % ROB_DEPTH;
                        end
                        fill--;
                    end
                end
                rob_pkg::OP_FLUSH: begin
                    foreach (occupied[j]) occupied[j] = 1'b0;
                    tail = head;
                    fill = 0;
                end
                rob_pkg::OP_READ: begin
                    r.data_value = value_mem[s];
                    r.kind_out   = kind_mem[s];
                    r.dest_out   = dest_mem[s];
                    r.pc_out     = pc_mem[s];
                    r.ready_out  = ready_mark[s];
                end
                default: begin
                end
            endcase
            r.head_slot  = rob_pkg::SLOT_W'(head);
            r.head_ready = occupied[head] && ready_mark[head];
            r.fill_level = rob_pkg::FILL_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected %0h, got %0h", name, e, a);
            end
        endfunction

        // Compare one result word against the oldest prediction.
        function void check_word(rob_pkg::rob_result_t got);
            rob_pkg::rob_result_t e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %0h", got);
                return;
            end
            e = pending_results.pop_front();
            compare_field("status", e.status, got.status);
            compare_field("slot", e.slot, got.slot);
            compare_field("hit", e.hit, got.hit);
            compare_field("data_value", 16'(e.data_value), 16'(got.data_value));
            compare_field("kind_out", e.kind_out, got.kind_out);
            compare_field("dest_out", e.dest_out, got.dest_out);
            compare_field("pc_out", e.pc_out, got.pc_out);
            compare_field("ready_out", e.ready_out, got.ready_out);
            compare_field("head_slot", e.head_slot, got.head_slot);
            compare_field("head_ready", e.head_ready, got.head_ready);
            compare_field("fill_level", e.fill_level, got.fill_level);
        endfunction
    endclass

    rob_shadow shadow = new();

    reorder_buffer_core #(
        .ROB_DEPTH (ROB_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Free-running clock, period 10.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Run limit in case the core hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // No idling on either side through a stretch in the middle of the run.
    function automatic bit idle_roll();
        if (words_accepted >= 150 && words_accepted < 450)
            return 1'b0;
        return $urandom_range(99) < 29;
    endfunction

    function automatic logic [rob_pkg::S_TDATA_W-1:0] pack_word(rob_pkg::rob_item_t w);
        logic [rob_pkg::S_TDATA_W-1:0] d;
        d        = '0;
        d[7:0]   = w.kind_in;
        d[23:8]  = w.dest_in;
        d[39:24] = w.pc_in;
        d[42:40] = w.slot_in;
        d[58:43] = w.value_in;
        return d;
    endfunction

    function automatic rob_pkg::rob_result_t unpack_result(
        logic [rob_pkg::M_TDATA_W-1:0] d,
        logic [rob_pkg::STATUS_W-1:0]  st);
        rob_pkg::rob_result_t r;
        r.status     = st;
        r.slot       = d[2:0];
        r.hit        = d[3];
        r.data_value = d[19:4];
        r.kind_out   = d[27:20];
        r.dest_out   = d[43:28];
        r.pc_out     = d[59:44];
        r.ready_out  = d[60];
        r.head_slot  = d[63:61];
        r.head_ready = d[64];
        r.fill_level = d[68:65];
        return r;
    endfunction

    function automatic rob_pkg::rob_item_t make_word(rob_pkg::rob_op_t op,
                                                     logic [rob_pkg::KIND_W-1:0] kind,
                                                     logic [rob_pkg::DATA_W-1:0] dest,
                                                     logic [rob_pkg::DATA_W-1:0] pc,
                                                     logic [rob_pkg::SLOT_W-1:0] slot,
                                                     logic [rob_pkg::DATA_W-1:0] value);
        rob_pkg::rob_item_t w;
        w.op       = op;
        w.kind_in  = kind;
        w.dest_in  = dest;
        w.pc_in    = pc;
        w.slot_in  = slot;
        w.value_in = value;
        return w;
    endfunction

    // Random word shaped by the current shadow state. Fill-heavy and
    // drain-heavy phases alternate so both the full and empty corners recur.
    function automatic rob_pkg::rob_item_t random_word(int unsigned n);
        rob_pkg::rob_item_t w;
        int unsigned        roll;
        int unsigned        alloc_w;
        bit                 any_written;
        w.kind_in  = ($urandom_range(3) == 0) ? rob_pkg::STORE_KIND
                                              : rob_pkg::KIND_W'($urandom);
        w.dest_in  = ($urandom_range(4) == 0) ? rob_pkg::DATA_W'($urandom)
                                              : dest_pool[$urandom_range(3)];
        w.pc_in    = rob_pkg::DATA_W'($urandom);
        w.slot_in  = rob_pkg::SLOT_W'($urandom);
        w.value_in = rob_pkg::DATA_W'($urandom);
        alloc_w    = ((n / 64) % 2 == 0) ? 40 : 20;
        roll       = $urandom_range(99);
        if (roll < alloc_w) begin
            w.op = rob_pkg::OP_ALLOC;
        end else begin
            roll = $urandom_range(99);
            if (roll < 30)      w.op = rob_pkg::OP_READY;
            else if (roll < 40) w.op = rob_pkg::OP_SETDST;
            else if (roll < 62) w.op = rob_pkg::OP_LOOKUP;
            else if (roll < 85) w.op = rob_pkg::OP_COMMIT;
            else if (roll < 89) w.op = rob_pkg::OP_FLUSH;
            else                w.op = rob_pkg::OP_READ;
        end
        // Mark-ready and set-destination mostly aim at occupied entries.
        if ((w.op == rob_pkg::OP_READY || w.op == rob_pkg::OP_SETDST) &&
            shadow.fill > 0 && $urandom_range(4) != 0)
            w.slot_in = rob_pkg::SLOT_W'((shadow.head + $urandom_range(shadow.fill - 1))
                                         % ROB_DEPTH);
        // Reads only touch entries that an allocate has filled in.
        if (w.op == rob_pkg::OP_READ) begin
            any_written = 1'b0;
            foreach (shadow.ever_allocated[j]) any_written |= shadow.ever_allocated[j];
            if (!any_written)
                w.op = rob_pkg::OP_LOOKUP;
            else
                while (!shadow.ever_allocated[w.slot_in])
                    w.slot_in = rob_pkg::SLOT_W'($urandom);
        end
        return w;
    endfunction

    // Offer one word, idling at random first, and wait for its acceptance.
    task automatic offer_word(rob_pkg::rob_item_t w);
        while (idle_roll()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= pack_word(w);
        s_tuser  <= w.op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        shadow.note_word(w);
        words_accepted++;
    endtask

    // Result side: check each accepted word, stall at random, hold off once.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready)
                shadow.check_word(unpack_result(m_tdata, m_tuser));
            if (!hold_done && words_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= !idle_roll();
        end
    end

    // Stimulus: reset, directed corners, then the random run.
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty buffer: commit is ignored, lookup misses, flush is harmless.
        offer_word(make_word(rob_pkg::OP_COMMIT, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_LOOKUP, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_FLUSH, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));

        // Fill every entry, then one allocate too many, then flush a full buffer.
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF));
        offer_word(make_word(rob_pkg::OP_ALLOC, rob_pkg::STORE_KIND, 16'h1234, 16'h0002,
                             3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'h61, 16'h1234, 16'h0003, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, rob_pkg::STORE_KIND, 16'hFFFF, 16'h0004,
                             3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'h01, 16'h1234, 16'h0005, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'h80, 16'h0000, 16'h8000, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'h07, 16'h0005, 16'h7FFF, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'h11, 16'h0001, 16'h0001, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_FLUSH, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));

        // Three entries: a ready load, a ready store and an unready entry.
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, rob_pkg::STORE_KIND, 16'hFFFF, 16'h0010,
                             3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_ALLOC, 8'h61, 16'h0000, 16'h0011, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_READY, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h8000));
        offer_word(make_word(rob_pkg::OP_READY, 8'd0, 16'h0000, 16'h0000, 3'd1, 16'h7FFF));
        offer_word(make_word(rob_pkg::OP_SETDST, 8'd0, 16'hFFFF, 16'h0000, 3'd2, 16'h0000));
        // The store and the unready entry must be skipped.
        offer_word(make_word(rob_pkg::OP_LOOKUP, 8'd0, 16'hFFFF, 16'h0000, 3'd0, 16'h0000));
        // Writing an unoccupied entry, then reading it and the head back.
        offer_word(make_word(rob_pkg::OP_READY, 8'd0, 16'h0000, 16'h0000, 3'd5, 16'h1111));
        offer_word(make_word(rob_pkg::OP_READ, 8'd0, 16'h0000, 16'h0000, 3'd5, 16'h0000));
        offer_word(make_word(rob_pkg::OP_READ, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));
        // Drain, ending with an unready head and a return of the pointers to 0.
        offer_word(make_word(rob_pkg::OP_COMMIT, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_COMMIT, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_COMMIT, 8'd0, 16'h0000, 16'h0000, 3'd0, 16'h0000));
        offer_word(make_word(rob_pkg::OP_LOOKUP, 8'd0, 16'hFFFF, 16'h0000, 3'd0, 16'h0000));

        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            // Once, let every outstanding result drain before going on.
            if (n == DRAIN_AT) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (shadow.pending_results.size() != 0);
            end
            offer_word(random_word(n));
        end
        s_tvalid <= 1'b0;

        while (shadow.pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
